[hdl/slfo_cc_pkg.sv]
// Shared constants, register map and quarter-wave sine table for the sine LFO CC generator.
package slfo_cc_pkg;

	localparam int SAMPLE_RATE  = 44100;
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
	localparam int TICK_SAMPLES = SAMPLE_RATE / 50;

	localparam logic [7:0] STATUS_CC = 8'hB0;

	localparam logic [2:0] REG_CTRL     = 3'd0;
	localparam logic [2:0] REG_STEP     = 3'd1;
	localparam logic [2:0] REG_STRENGTH = 3'd2;
	localparam logic [2:0] REG_OFFSET   = 3'd3;
	localparam logic [2:0] REG_LENGTH   = 3'd4;

	localparam logic [6:0]  RST_CTRL     = 7'd1;
	localparam logic [23:0] RST_STEP     = 24'd167772;
	localparam logic [16:0] RST_STRENGTH = 17'd65536;
	localparam logic [15:0] RST_OFFSET   = 16'd0;
	localparam logic [30:0] RST_LENGTH   = 31'd44100;

	localparam logic [16:0] FULL_STRENGTH = 17'd65536;

	typedef logic [SINE_ENTRIES-1:0][14:0] sine_tab_t;

	// Odd polynomial in Q30, rounded to Q15; evaluated at elaboration only.
	function automatic sine_tab_t build_sine_table();
		sine_tab_t         tab;
		longint unsigned   u;
		longint unsigned   u2;
		longint unsigned   p;
		longint unsigned   r;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			u  = (longint'(2 * k + 1) << 30) >> (SINE_BITS + 1);
			u2 = (u * u) >> 30;
			p  = 64'd172228;
			p  = 64'd5027044 - ((u2 * p) >> 30);
			p  = 64'd85569278 - ((u2 * p) >> 30);
			p  = 64'd693598671 - ((u2 * p) >> 30);
			p  = 64'd1686629713 - ((u2 * p) >> 30);
			r  = (u * p) >> 30;
			r  = (r + 64'd16384) >> 15;
			if (r > 64'd32767) begin
				r = 64'd32767;
			end
			tab[k] = r[14:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

[hdl/sine_lfo_control_change_generator_core.sv]
// Sine LFO control-change generator: config registers, phase/position state, 4-stage datapath.
// An emitting tick passes through stages s1, s2, s3 and the output register before its event shows.
// Throughput: one tick per cycle; the whole pipeline holds while the output is stalled.
// A tick at or past the item length makes no event and leaves phase and position alone, but for a restart.
// Reset (arst_n low, async) clears phase, position and pipeline valids and loads
// the register defaults; no clearing pass.
module sine_lfo_control_change_generator_core
	import slfo_cc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  status_byte,
	output logic [6:0]  controller,
	output logic [6:0]  cc_value,
	output logic [30:0] sample_frame,
	output logic        last_event
);

	logic [6:0]         ctrl_num_q;
	logic [23:0]        phase_step_q;
	logic [16:0]        strength_q;
	logic signed [15:0] offset_q;
	logic [30:0]        item_len_q;
	logic               wr_en;

	logic [23:0] phase_q;
	logic [31:0] pos_q;

	logic        pipe_en;
	logic        accept;
	logic [31:0] eff_pos;
	logic [23:0] eff_phase;
	logic [31:0] next_pos;
	logic        emit;
	logic        last_w;

	logic        valid_s1, valid_s2, valid_s3, out_valid_q;
	logic [23:0] phase_s1;
	logic [30:0] pos_s1, pos_s2, pos_s3;
	logic        last_s1, last_s2, last_s3;
	logic [14:0] sine_mag_s2;
	logic        sine_neg_s2;
	logic signed [16:0] t_s3;

	logic [6:0]  cc_value_q;
	logic [6:0]  ctrl_q;
	logic [30:0] frame_q;
	logic        last_q;

	logic [16:0] st_sat;
	logic [15:0] abs_off;
	logic [15:0] head;
	logic [31:0] mag_d;
	logic [31:0] mag_q;

	logic [SINE_BITS+1:0] idx;
	logic [SINE_BITS-1:0] tab_addr;
	logic [14:0]          sine_mag_d;

	logic [46:0]        prod;
	logic [15:0]        tmag;
	logic signed [16:0] t_d;

	logic signed [17:0] v;
	logic signed [17:0] bias;
	logic signed [24:0] num;
	logic [6:0]         val_d;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_num_q   <= RST_CTRL;
			phase_step_q <= RST_STEP;
			strength_q   <= RST_STRENGTH;
			offset_q     <= RST_OFFSET;
			item_len_q   <= RST_LENGTH;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_CTRL:     ctrl_num_q   <= pwdata[6:0];
				REG_STEP:     phase_step_q <= pwdata[23:0];
				REG_STRENGTH: strength_q   <= pwdata[16:0];
				REG_OFFSET:   offset_q     <= pwdata[15:0];
				REG_LENGTH:   item_len_q   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CTRL:     prdata = {25'd0, ctrl_num_q};
			REG_STEP:     prdata = {8'd0, phase_step_q};
			REG_STRENGTH: prdata = {15'd0, strength_q};
			REG_OFFSET:   prdata = {16'd0, offset_q};
			REG_LENGTH:   prdata = {1'b0, item_len_q};
			default:      prdata = 32'd0;
		endcase
	end

	// depth scale, registered from the config registers
	always_comb begin
		st_sat  = (strength_q > FULL_STRENGTH) ? FULL_STRENGTH : strength_q;
		abs_off = offset_q[15] ? 16'(-offset_q) : offset_q;
		head    = 16'h8000 - abs_off;
		mag_d   = 32'({16'd0, st_sat} * {17'd0, head});
	end

	always_ff @(posedge clk) begin
		mag_q <= mag_d;
	end

	// tick acceptance and state update
	assign pipe_en  = !out_valid_q || out_ready;
	assign in_ready = pipe_en;
	assign accept   = in_valid && pipe_en;

	always_comb begin
		eff_pos   = restart ? 32'd0 : pos_q;
		eff_phase = restart ? 24'd0 : phase_q;
		next_pos  = eff_pos + 32'(TICK_SAMPLES);
		emit      = eff_pos < {1'b0, item_len_q};
		last_w    = next_pos >= {1'b0, item_len_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 24'd0;
			pos_q   <= 32'd0;
		end else if (accept) begin
			if (emit) begin
				phase_q <= eff_phase + phase_step_q;
				pos_q   <= next_pos;
			end else begin
				phase_q <= eff_phase;
				pos_q   <= eff_pos;
			end
		end
	end

	// quarter-wave lookup
	always_comb begin
		idx        = phase_s1[23 -: SINE_BITS + 2];
		tab_addr   = idx[0 +: SINE_BITS];
		if (idx[SINE_BITS]) begin
			tab_addr = ~idx[0 +: SINE_BITS];
		end
		sine_mag_d = SINE_TABLE[tab_addr];
	end

	// depth multiply
	always_comb begin
		prod = {15'd0, mag_q} * {32'd0, sine_mag_s2};
		tmag = prod[46:31];
		t_d  = sine_neg_s2 ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
	end

	// offset, scale to 0..127, saturate
	always_comb begin
		v    = {{2{offset_q[15]}}, offset_q} + {t_s3[16], t_s3};
		bias = v + 18'sd32768;
		num  = {{7{bias[17]}}, bias} * 25'sd127;
		if (num[24]) begin
			val_d = 7'd0;
		end else if (num[23:16] > 8'd127) begin
			val_d = 7'd127;
		end else begin
			val_d = num[22:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			valid_s1    <= accept && emit;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			phase_s1    <= eff_phase;
			pos_s1      <= eff_pos[30:0];
			last_s1     <= last_w;
			sine_mag_s2 <= sine_mag_d;
			sine_neg_s2 <= idx[SINE_BITS+1];
			pos_s2      <= pos_s1;
			last_s2     <= last_s1;
			t_s3        <= t_d;
			pos_s3      <= pos_s2;
			last_s3     <= last_s2;
			cc_value_q  <= val_d;
			ctrl_q      <= ctrl_num_q;
			frame_q     <= pos_s3;
			last_q      <= last_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign status_byte  = STATUS_CC;
	assign controller   = ctrl_q;
	assign cc_value     = cc_value_q;
	assign sample_frame = frame_q;
	assign last_event   = last_q;

	// an emitting tick advances position by one tick
	a_pos_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (pos_q == $past(next_pos)))
		else $error("position did not advance by one tick");

	// a tick past the end leaves phase where restart put it
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !emit) |=> (phase_q == $past(eff_phase)))
		else $error("phase moved on a tick without event");

	// every event lies inside the item
	a_frame_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, frame_q} < {1'b0, item_len_q}))
		else $error("event frame offset beyond item length");

	// last flag matches the item end
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |->
		(({1'b0, frame_q} + 32'(TICK_SAMPLES)) >= {1'b0, item_len_q}))
		else $error("last event flagged before item end");

endmodule
